// ===== design/dpts_pkg.sv =====
// Shared types and constants for the dynamic priority task selector.
package dpts_pkg;

    localparam int TASK_W = 3;
    localparam int TAG_W = 8;
    localparam int MAX_RANKS = 8;

    typedef enum logic [1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_SEL   = 2'd1,
        FUNC_YIELD = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BE_IDLE = 2'd0,
        BE_SCAN = 2'd1,
        BE_SHIFT = 2'd2
    } t_be_state;

    localparam logic ADDR_PRIO = 1'b0;
    localparam logic ADDR_LEN  = 1'b1;

    localparam logic [23:0] PRIO_RESET = 24'd16434824;
    localparam logic [3:0]  LEN_RESET  = 4'd8;

    typedef struct packed {
        logic [1:0]        func;
        logic [TASK_W-1:0] task_id;
        logic [TAG_W-1:0]  instance_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [TASK_W-1:0] sel_task_id;
        logic [TAG_W-1:0]  sel_instance_tag;
        logic              by_priority;
    } t_out;

endpackage

// ===== design/dpts_front.sv =====
// Front end: accepts requests and holds them in a small command queue.
module dpts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  dpts_pkg::t_in  i_req,
    output logic           o_busy,
    input  logic           i_pop,
    output logic           o_valid,
    output dpts_pkg::t_in  o_req
);
    import dpts_pkg::*;

    // two-entry queue
    t_in        r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic       push;

    assign o_busy  = r_cnt[1];
    assign push    = i_start && !r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= !r_wr;
            if (i_pop) r_rd <= !r_rd;
        end
        if (push) r_q[r_wr] <= i_req;
    end
endmodule

// ===== design/dpts_back.sv =====
// Back end: ready queue, rank walk and removal with compaction.
module dpts_back #(
    parameter int NUM_TASKS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dpts_pkg::t_in  i_req,
    output logic           o_pop,
    input  logic [23:0]    i_prio,
    input  logic [3:0]     i_len,
    output logic           o_strobe,
    output dpts_pkg::t_out o_res
);
    import dpts_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TASK_W-1:0] r_task [QUEUE_DEPTH];
    logic [TAG_W-1:0]  r_tag  [QUEUE_DEPTH];
    logic [CW-1:0]     r_count, n_count;
    logic              r_yv, n_yv, r_lv, n_lv;
    logic [TASK_W-1:0] r_yt, n_yt, r_lt, n_lt;
    t_be_state         r_st, n_st;
    logic [2:0]        r_rank, n_rank;
    logic [QW-1:0]     r_pos, n_pos;
    logic              r_found, n_found;
    t_out              r_res, n_res;
    logic              r_stb, n_stb;

    logic [3:0]        ranks;
    logic [TASK_W-1:0] want;
    logic              hit;
    logic [QW-1:0]     hit_pos;
    logic              enq_we, shift_en;

    assign ranks = (i_len > 4'd8) ? 4'd8 : i_len;
    assign want  = i_prio[r_rank*3 +: 3];

    // oldest matching entry among the valid ones
    always_comb begin
        hit = 1'b0;
        hit_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (CW'(i) < r_count && r_task[i] == want) begin
                hit = 1'b1;
                hit_pos = QW'(i);
            end
        end
    end

    always_comb begin
        n_st = r_st; n_rank = r_rank; n_pos = r_pos; n_found = r_found;
        n_count = r_count; n_yv = r_yv; n_yt = r_yt; n_lv = r_lv; n_lt = r_lt;
        n_res = r_res; n_stb = 1'b0;
        o_pop = 1'b0; enq_we = 1'b0; shift_en = 1'b0;
        case (r_st)
            BE_IDLE: begin
                if (i_valid) begin
                    n_res = '0;
                    case (t_func'(i_req.func))
                        FUNC_ENQ: begin
                            o_pop = 1'b1; n_stb = 1'b1;
                            if (r_count >= CW'(QUEUE_DEPTH)) n_res.status = ST_FULL;
                            else begin
                                enq_we = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        FUNC_SEL: begin
                            if (r_count == '0) begin
                                o_pop = 1'b1; n_stb = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_st = BE_SCAN; n_rank = '0;
                                n_pos = '0; n_found = 1'b0;
                            end
                        end
                        FUNC_YIELD: begin
                            o_pop = 1'b1; n_stb = 1'b1;
                            if (r_lv) begin n_yv = 1'b1; n_yt = r_lt; end
                        end
                        default: begin
                            o_pop = 1'b1; n_stb = 1'b1;
                        end
                    endcase
                end
            end
            BE_SCAN: begin
                // one rank per cycle
                if ({1'b0, r_rank} >= ranks) begin
                    n_st = BE_SHIFT;
                end else begin
                    if ({2'b0, want} < 5'(NUM_TASKS) && !(r_yv && want == r_yt) && hit)
                    begin
                        n_pos = hit_pos; n_found = 1'b1; n_st = BE_SHIFT;
                    end else if (r_rank == 3'd7) begin
                        n_st = BE_SHIFT;
                    end
                    n_rank = r_rank + 3'd1;
                end
            end
            BE_SHIFT: begin
                o_pop = 1'b1; n_stb = 1'b1; shift_en = 1'b1;
                n_res.status = ST_OK;
                n_res.sel_task_id = r_task[r_pos];
                n_res.sel_instance_tag = r_tag[r_pos];
                n_res.by_priority = r_found;
                n_lv = 1'b1; n_lt = r_task[r_pos];
                n_yv = 1'b0; n_yt = '0;
                n_count = r_count - 1'b1;
                n_st = BE_IDLE;
            end
            default: n_st = BE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BE_IDLE; r_count <= '0; r_yv <= 1'b0; r_yt <= '0;
            r_lv <= 1'b0; r_lt <= '0; r_stb <= 1'b0; r_rank <= '0;
            r_pos <= '0; r_found <= 1'b0; r_res <= '0;
        end else begin
            r_st <= n_st; r_count <= n_count; r_yv <= n_yv; r_yt <= n_yt;
            r_lv <= n_lv; r_lt <= n_lt; r_stb <= n_stb; r_rank <= n_rank;
            r_pos <= n_pos; r_found <= n_found; r_res <= n_res;
        end
        if (enq_we) begin
            r_task[r_count[QW-1:0]] <= i_req.task_id;
            r_tag[r_count[QW-1:0]]  <= i_req.instance_tag;
        end
        if (shift_en) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (QW'(i) >= r_pos) begin
                    r_task[i] <= r_task[i+1];
                    r_tag[i]  <= r_tag[i+1];
                end
            end
        end
    end

    assign o_strobe = r_stb;
    assign o_res    = r_res;
endmodule

// ===== design/dynamic_priority_task_selector.sv =====
// Top level: APB register file plus front command queue and back scheduler.
// An enqueue, a yield or a select on an empty queue passes from the front queue
// into the back end, which registers its result and strobe. A select walks
// one priority rank per cycle through at most eight ranks (list_length is
// capped at eight) and then removes the chosen entry from the ready queue.
// Requests may wait in the front queue behind earlier ones. The front holds two requests;
// busy rises when both slots are full. Each result is strobed for exactly one
// cycle and the receiver cannot stall it.
module dynamic_priority_task_selector #(
    parameter int NUM_TASKS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dpts_pkg::t_in  i_req,
    output logic           o_strobe,
    output dpts_pkg::t_out o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import dpts_pkg::*;

    logic [23:0] r_prio;
    logic [3:0]  r_len;
    logic        q_valid, q_pop;
    t_in         q_req;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_LEN) ? {28'd0, r_len} :
                    (paddr[1:0] == 2'd0 ? {8'd0, r_prio} : 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= PRIO_RESET;
            r_len  <= LEN_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == ADDR_PRIO) r_prio <= pwdata[23:0];
            else r_len <= pwdata[3:0];
        end
    end

    dpts_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_req, .o_busy(busy),
        .i_pop(q_pop), .o_valid(q_valid), .o_req(q_req)
    );

    dpts_back #(.NUM_TASKS(NUM_TASKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req), .o_pop(q_pop),
        .i_prio(r_prio), .i_len(r_len), .o_strobe, .o_res
    );
endmodule

// ===== bench/dynamic_priority_task_selector_tb.sv =====
// Testbench for the dynamic priority task selector: random and directed requests.
module dynamic_priority_task_selector_tb;
    import dpts_pkg::*;

    localparam int N_TASKS = 8;
    localparam int Q_DEPTH = 16;

    class sched_scoreboard;
        logic [23:0] prio;
        logic [3:0]  len;
        t_in         rq[$];
        logic        yv;
        logic [2:0]  yt;
        logic        lv;
        logic [2:0]  lt;
        t_out        pending[$];
        int          errors;

        function void clear();
            prio = PRIO_RESET;
            len = LEN_RESET;
            rq.delete();
            yv = 1'b0; yt = '0; lv = 1'b0; lt = '0;
            pending.delete();
            errors = 0;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(t_in r);
            t_out o;
            int ranks, pos;
            logic found;
            logic [2:0] want;
            o = '0;
            found = 1'b0;
            pos = 0;
            if (r.func == FUNC_ENQ) begin
                if (rq.size() >= Q_DEPTH) o.status = ST_FULL;
                else rq.insert(rq.size(), r);
            end else if (r.func == FUNC_SEL) begin
                if (rq.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    ranks = (len > 8) ? 8 : int'(len);
                    for (int k = 0; k < ranks && !found; k++) begin
                        want = prio[3*k +: 3];
                        if (int'(want) >= N_TASKS) continue;
                        if (yv && want == yt) continue;
                        for (int i = 0; i < rq.size(); i++)
                            if (rq[i].task_id == want) begin
                                pos = i;
                                found = 1'b1;
                                break;
                            end
                    end
                    o.sel_task_id = rq[pos].task_id;
                    o.sel_instance_tag = rq[pos].instance_tag;
                    o.by_priority = found;
                    lv = 1'b1;
                    lt = rq[pos].task_id;
                    yv = 1'b0;
                    yt = '0;
                    rq.delete(pos);
                end
            end else if (r.func == FUNC_YIELD) begin
                if (lv) begin
                    yv = 1'b1;
                    yt = lt;
                end
            end
            pending.insert(pending.size(), o);
        endfunction

        function void check_result(t_out a);
            t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a.status !== e.status || a.sel_task_id !== e.sel_task_id ||
                a.sel_instance_tag !== e.sel_instance_tag ||
                a.by_priority !== e.by_priority) begin
                $display("%0t: mismatch expected %h actual %h", $time, e, a);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_req;
    logic        o_strobe;
    t_out        o_res;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sched_scoreboard sb;
    int idle_pct;

    dynamic_priority_task_selector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_strobe(o_strobe), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("dynamic_priority_task_selector test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_res);
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        start <= 0;
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        if (addr == 3'd0) sb.prio = data[23:0];
        else sb.len = data[3:0];
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // One request: optional idle gap, then hold start until accepted.
    // start stays high afterwards so the next request can follow at once.
    task automatic send_request(input t_in r);
        logic taken;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_req <= r;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        sb.note_request(r);
    endtask

    task automatic send_fields(input t_func f, input int tid, input int tag);
        t_in r;
        r.func = f;
        r.task_id = 3'(tid);
        r.instance_tag = 8'(tag);
        send_request(r);
    endtask

    // Let everything drain before touching the registers.
    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        start <= 0;
        while (sb.pending.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_request();
        int p;
        t_in r;
        p = $urandom_range(99);
        r.task_id = 3'($urandom_range(7));
        r.instance_tag = 8'($urandom_range(255));
        if (p < 48) r.func = FUNC_ENQ;
        else if (p < 85) r.func = FUNC_SEL;
        else if (p < 97) r.func = FUNC_YIELD;
        else r.func = FUNC_NONE;
        send_request(r);
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 0; start = 0; i_req = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        idle_pct = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: select on empty, yield before select, fill past full
        send_fields(FUNC_SEL, 0, 0);
        send_fields(FUNC_YIELD, 0, 0);
        send_fields(FUNC_NONE, 7, 255);
        for (int i = 0; i < 17; i++) send_fields(FUNC_ENQ, i % 8, (i == 16) ? 255 : i * 15);
        send_fields(FUNC_SEL, 0, 0);
        send_fields(FUNC_YIELD, 0, 0);
        send_fields(FUNC_SEL, 0, 0);
        send_fields(FUNC_SEL, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 19;
                default: idle_pct = 0;
            endcase
            case (ph)
                0: begin reg_write(3'd0, 32'h00FA_C688); reg_write(3'd4, 32'd0); end
                1: begin reg_write(3'd0, 32'h00FF_FFFF); reg_write(3'd4, 32'd15); end
                2: begin reg_write(3'd0, 32'h0000_0000); reg_write(3'd4, 32'd8); end
                3: begin reg_write(3'd0, 32'h00FA_C688); reg_write(3'd4, 32'd9); end
                default: begin
                    reg_write(3'd0, $urandom_range(32'hFFFFFF));
                    reg_write(3'd4, $urandom_range(15));
                end
            endcase
            for (int n = 0; n < 215; n++) random_request();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dynamic_priority_task_selector test passed");
        else
            $display("dynamic_priority_task_selector test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/dpts_pkg.sv
design/dpts_front.sv
design/dpts_back.sv
design/dynamic_priority_task_selector.sv
bench/dynamic_priority_task_selector_tb.sv
